/* rtl/core/tpsq_pkg.sv */
// Types, constants and helper functions of the three-position switch qualifier.
// No dependencies; used by tpsq_step and three_position_switch_qualifier_core.
package tpsq_pkg;

	localparam int VOLTAGE_BITS   = 13;
	localparam int TIME_BITS      = 32;
	localparam int DEBOUNCE_BITS  = 16;
	localparam int CFG_INDEX_BITS = 3;
	localparam int CFG_DATA_BITS  = 16;

	// reset values of the configuration registers
	localparam logic [VOLTAGE_BITS-1:0]  BACK_LOW_RST   = VOLTAGE_BITS'(775);
	localparam logic [VOLTAGE_BITS-1:0]  BACK_HIGH_RST  = VOLTAGE_BITS'(875);
	localparam logic [VOLTAGE_BITS-1:0]  FRONT_LOW_RST  = VOLTAGE_BITS'(2425);
	localparam logic [VOLTAGE_BITS-1:0]  FRONT_HIGH_RST = VOLTAGE_BITS'(2525);
	localparam logic [DEBOUNCE_BITS-1:0] DEBOUNCE_RST   = DEBOUNCE_BITS'(50);

	typedef enum logic [CFG_INDEX_BITS-1:0] {
		REG_BACK_LOW   = 3'd0,
		REG_BACK_HIGH  = 3'd1,
		REG_FRONT_LOW  = 3'd2,
		REG_FRONT_HIGH = 3'd3,
		REG_DEBOUNCE   = 3'd4
	} cfg_reg_t;

	typedef enum logic [1:0] {
		POS_NEUTRAL = 2'd0,
		POS_BACK    = 2'd1,
		POS_FRONT   = 2'd2
	} pos_t;

	typedef enum logic [2:0] {
		PH_NEUTRAL       = 3'd0,
		PH_CONF_BACK     = 3'd1,
		PH_BACK          = 3'd2,
		PH_CONF_FRONT    = 3'd3,
		PH_FRONT         = 3'd4,
		PH_CONF_NEUTRAL  = 3'd5
	} phase_t;

	typedef struct packed {
		logic [VOLTAGE_BITS-1:0]  back_low;
		logic [VOLTAGE_BITS-1:0]  back_high;
		logic [VOLTAGE_BITS-1:0]  front_low;
		logic [VOLTAGE_BITS-1:0]  front_high;
		logic [DEBOUNCE_BITS-1:0] debounce;
	} cfg_t;

	typedef struct packed {
		phase_t                phase;
		pos_t                  confirmed;
		logic [TIME_BITS-1:0]  start;
	} state_t;

	function automatic logic is_stable(input phase_t ph);
		return (ph == PH_NEUTRAL) || (ph == PH_BACK) || (ph == PH_FRONT);
	endfunction

	function automatic logic is_confirm(input phase_t ph);
		return (ph == PH_CONF_BACK) || (ph == PH_CONF_FRONT) || (ph == PH_CONF_NEUTRAL);
	endfunction

	// position held by a stable phase, or aimed at by a confirming phase
	function automatic pos_t pos_of_phase(input phase_t ph);
		pos_t p;
		case (ph)
			PH_BACK, PH_CONF_BACK:   p = POS_BACK;
			PH_FRONT, PH_CONF_FRONT: p = POS_FRONT;
			default:                 p = POS_NEUTRAL;
		endcase
		return p;
	endfunction

	function automatic phase_t stable_of(input pos_t p);
		phase_t ph;
		case (p)
			POS_BACK:  ph = PH_BACK;
			POS_FRONT: ph = PH_FRONT;
			default:   ph = PH_NEUTRAL;
		endcase
		return ph;
	endfunction

	function automatic phase_t confirm_of(input pos_t p);
		phase_t ph;
		case (p)
			POS_BACK:  ph = PH_CONF_BACK;
			POS_FRONT: ph = PH_CONF_FRONT;
			default:   ph = PH_CONF_NEUTRAL;
		endcase
		return ph;
	endfunction

endpackage

/* rtl/core/three_position_switch_qualifier_core.sv */
// Three-position switch qualifier: input register, combinational state update and
// result register. Depends on tpsq_pkg and tpsq_step.
//
// Usage:
//   Each request on the input channel (in_valid/in_stall) carries one voltage
//   sample sample_mv and the millisecond timestamp now_ms. It is taken at a
//   rising edge with in_valid high and in_stall low.
//   Each request yields exactly one result on the output channel
//   (out_valid/out_stall): the confirmed position and the phase after the
//   update. A result is taken at an edge with out_valid high, out_stall low.
//   A request passes the input register and then the result register before
//   out_valid rises; throughput is one request per cycle while out_stall is
//   low, set by the single state update between the two registers.
//   While out_stall holds, the result stays put and one further request waits
//   in the input register; in_stall then rises until the result is taken.
//   Configuration is written through cfg_wr_en/cfg_index/cfg_data; the user
//   must write it only while no request is in flight, which the block itself
//   does not enforce; unknown indexes are ignored.
//   Reset (arst_n low) empties both registers, restores the threshold and
//   debounce defaults and puts the machine in the neutral stable phase with
//   neutral confirmed and a start time of zero.
module three_position_switch_qualifier_core
	import tpsq_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_wr_en,
	input  logic [CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [CFG_DATA_BITS-1:0]  cfg_data,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic [VOLTAGE_BITS-1:0]   sample_mv,
	input  logic [TIME_BITS-1:0]      now_ms,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic [1:0]                position,
	output logic [2:0]                phase
);

	cfg_t                     cfg_q;
	state_t                   state_q;
	state_t                   state_nxt;
	logic                     valid_s1;
	logic [VOLTAGE_BITS-1:0]  voltage_s1;
	logic [TIME_BITS-1:0]     now_s1;
	logic                     valid_s2;
	pos_t                     position_s2;
	phase_t                   phase_s2;
	logic                     in_take;
	logic                     advance;

	// handshake: move stage 1 on when the result register is free or drained
	assign advance  = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall = valid_s1 && !advance;
	assign in_take  = in_valid && !in_stall;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.back_low   <= BACK_LOW_RST;
			cfg_q.back_high  <= BACK_HIGH_RST;
			cfg_q.front_low  <= FRONT_LOW_RST;
			cfg_q.front_high <= FRONT_HIGH_RST;
			cfg_q.debounce   <= DEBOUNCE_RST;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_BACK_LOW:   cfg_q.back_low   <= cfg_data[VOLTAGE_BITS-1:0];
				REG_BACK_HIGH:  cfg_q.back_high  <= cfg_data[VOLTAGE_BITS-1:0];
				REG_FRONT_LOW:  cfg_q.front_low  <= cfg_data[VOLTAGE_BITS-1:0];
				REG_FRONT_HIGH: cfg_q.front_high <= cfg_data[VOLTAGE_BITS-1:0];
				REG_DEBOUNCE:   cfg_q.debounce   <= cfg_data[DEBOUNCE_BITS-1:0];
				default:        cfg_q            <= cfg_q;
			endcase
		end
	end

	// input register: valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	// input register: payload
	always_ff @(posedge clk) begin
		if (in_take) begin
			voltage_s1 <= sample_mv;
			now_s1     <= now_ms;
		end
	end

	// state update for the request in stage 1
	tpsq_step u_step (
		.cfg     (cfg_q),
		.voltage (voltage_s1),
		.now     (now_s1),
		.cur     (state_q),
		.nxt     (state_nxt)
	);

	// machine state: advance once per request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.phase     <= PH_NEUTRAL;
			state_q.confirmed <= POS_NEUTRAL;
			state_q.start     <= '0;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	// result register: valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (!out_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	// result register: payload
	always_ff @(posedge clk) begin
		if (advance) begin
			position_s2 <= state_nxt.confirmed;
			phase_s2    <= state_nxt.phase;
		end
	end

	assign out_valid = valid_s2;
	assign position  = 2'(position_s2);
	assign phase     = 3'(phase_s2);

	// a confirming phase never aims at the position already confirmed
	a_confirm_target: assert property (@(posedge clk) disable iff (!arst_n)
		is_confirm(state_q.phase) |-> (pos_of_phase(state_q.phase) != state_q.confirmed))
		else $error("confirming phase targets the confirmed position");

	// an update from a stable phase confirms that phase's position
	a_stable_confirms: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && is_stable(state_q.phase))
		|=> (state_q.confirmed == $past(pos_of_phase(state_q.phase))))
		else $error("stable phase did not confirm its position");

	// state only moves with a request
	a_state_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> $stable(state_q))
		else $error("state changed without a request");

	// every request handed on leaves a result waiting
	a_result_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> valid_s2)
		else $error("request lost between stages");

	// input is held back only while both stages are occupied and the output stalls
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && valid_s2 && out_stall))
		else $error("input stalled without cause");

endmodule

/* rtl/core/tpsq_step.sv */
// Next-state logic of the switch qualifier: voltage classification, phase
// transitions and debounce timing for one request. Depends on tpsq_pkg.
module tpsq_step
	import tpsq_pkg::*;
(
	input  cfg_t                    cfg,
	input  logic [VOLTAGE_BITS-1:0] voltage,
	input  logic [TIME_BITS-1:0]    now,
	input  state_t                  cur,
	output state_t                  nxt
);

	logic [2:0]            match;
	logic [TIME_BITS-1:0]  elapsed;
	logic                  time_up;
	phase_t                nxt_phase;
	logic                  load_start;

	// classify the voltage, one flag per position
	assign match[POS_NEUTRAL] = (voltage > cfg.back_high) && (voltage < cfg.front_low);
	assign match[POS_BACK]    = voltage < cfg.back_low;
	assign match[POS_FRONT]   = voltage > cfg.front_high;

	// modular elapsed time since confirmation began
	assign elapsed = now - cur.start;
	assign time_up = elapsed > TIME_BITS'(cfg.debounce);

	// phase transitions
	always_comb begin
		logic [1:0] here;
		logic [1:0] target;
		logic [1:0] prev;
		logic [1:0] other;
		logic       found;
		here       = 2'(pos_of_phase(cur.phase));
		target     = here;
		prev       = 2'(cur.confirmed);
		other      = 2'(2'd3 - prev - target);
		found      = 1'b0;
		nxt_phase  = cur.phase;
		load_start = 1'b0;
		case (cur.phase)
			PH_NEUTRAL, PH_BACK, PH_FRONT: begin
				// first other position that the voltage shows, in ascending order
				for (int o = 0; o < 3; o++) begin
					if (!found && (2'(o) != here) && match[o]) begin
						found      = 1'b1;
						nxt_phase  = confirm_of(pos_t'(2'(o)));
						load_start = 1'b1;
					end
				end
			end
			PH_CONF_BACK, PH_CONF_FRONT, PH_CONF_NEUTRAL: begin
				if ((prev != target) && (prev != 2'd3)) begin
					if (match[prev]) begin
						nxt_phase = stable_of(pos_t'(prev));
					end else if (match[other]) begin
						nxt_phase  = confirm_of(pos_t'(other));
						load_start = 1'b1;
					end else if (match[target] && time_up) begin
						nxt_phase = stable_of(pos_t'(target));
					end
				end
			end
			default: begin
				nxt_phase = cur.phase;
			end
		endcase
	end

	// outputs: confirmed position follows a stable phase, start time on entry
	always_comb begin
		nxt.phase     = nxt_phase;
		nxt.confirmed = is_stable(cur.phase) ? pos_of_phase(cur.phase) : cur.confirmed;
		nxt.start     = load_start ? now : cur.start;
	end

endmodule
